>>> rtl/core/b64e_pkg.sv
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
package b64e_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

  // Pending byte counts
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  // Character slot of a group
  localparam logic [1:0] SLOT_LAST = 2'd3;

  // One encoded group: four characters, slot 0 goes out first
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic            last;
  } group_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Map a 6-bit index onto the standard alphabet
  function automatic logic [7:0] sym(input logic [5:0] idx);
    logic [7:0] v;
    v = {2'b00, idx};
    if (idx < 6'd26) begin
      sym = 8'h41 + v;
    end else if (idx < 6'd52) begin
      sym = 8'h61 + v - 8'd26;
    end else if (idx < 6'd62) begin
      sym = 8'h30 + v - 8'd52;
    end else if (idx == 6'd62) begin
      sym = 8'h2B;
    end else begin
      sym = 8'h2F;
    end
  endfunction

endpackage

>>> rtl/core/b64e_front.sv
// Front end: accepts bytes, keeps the pending pair and forms encoded groups.
module b64e_front import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  q_stat_t    q_stat,
  output logic       full,
  output logic       grp_valid,
  output group_t     grp
);

  logic [7:0] pend0;
  logic [7:0] pend1;
  logic [1:0] cnt;
  logic       take;

  assign full = q_stat.full;
  assign take = push && !q_stat.full;

  // A group is complete on the third byte or on any last byte
  assign grp_valid = take && (cnt == CNT_TWO || last_byte);

  // Form the four characters of the group
  always_comb begin
    grp.last = 1'b1;
    if (cnt == CNT_TWO) begin
      grp.chars[0] = sym(pend0[7:2]);
      grp.chars[1] = sym({pend0[1:0], pend1[7:4]});
      grp.chars[2] = sym({pend1[3:0], data_byte[7:6]});
      grp.chars[3] = sym(data_byte[5:0]);
      grp.last     = last_byte;
    end else if (cnt == CNT_ONE) begin
      grp.chars[0] = sym(pend0[7:2]);
      grp.chars[1] = sym({pend0[1:0], data_byte[7:4]});
      grp.chars[2] = sym({data_byte[3:0], 2'b00});
      grp.chars[3] = PAD_CHAR;
    end else begin
      grp.chars[0] = sym(data_byte[7:2]);
      grp.chars[1] = sym({data_byte[1:0], 4'b0000});
      grp.chars[2] = PAD_CHAR;
      grp.chars[3] = PAD_CHAR;
    end
  end

  // Pending count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= CNT_NONE;
    end else if (take) begin
      if (grp_valid) begin
        cnt <= CNT_NONE;
      end else begin
        cnt <= cnt + 2'd1;
      end
    end
  end

  // Pending bytes
  always_ff @(posedge clk) begin
    if (take && !grp_valid) begin
      if (cnt == CNT_NONE) begin
        pend0 <= data_byte;
      end else begin
        pend1 <= data_byte;
      end
    end
  end

endmodule

>>> rtl/core/b64e_queue.sv
// Short group queue between the front and back ends.
module b64e_queue import b64e_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  group_t  wr_data,
  input  logic    rd_en,
  output group_t  rd_data,
  output q_stat_t q_stat
);

  group_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QCNT_W-1:0]   count;
  logic                do_wr;
  logic                do_rd;

  assign q_stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_wr        = wr_en && !q_stat.full;
  assign do_rd        = rd_en && !q_stat.empty;
  assign rd_data      = entries[rptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wptr] <= wr_data;
    end
  end

endmodule

>>> rtl/core/b64e_back.sv
// Back end: holds one group and sends its characters out one per cycle while pop is high.
module b64e_back import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  group_t     q_data,
  input  q_stat_t    q_stat,
  output logic       q_rd,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_char,
  output logic       last_char
);

  group_t     cur;
  logic       cur_valid;
  logic [1:0] slot;
  logic       done;

  assign empty     = !cur_valid;
  assign out_char  = cur.chars[slot];
  assign last_char = cur.last && (slot == SLOT_LAST);

  // Current group is finished when its final character is taken
  assign done = cur_valid && pop && (slot == SLOT_LAST);
  assign q_rd = !q_stat.empty && (!cur_valid || done);

  // Valid flag and slot counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      slot      <= 2'd0;
    end else begin
      if (q_rd) begin
        cur_valid <= 1'b1;
        slot      <= 2'd0;
      end else if (done) begin
        cur_valid <= 1'b0;
        slot      <= 2'd0;
      end else if (cur_valid && pop) begin
        slot <= slot + 2'd1;
      end
    end
  end

  // Group payload
  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_data;
    end
  end

endmodule

>>> rtl/core/base64_stream_encoder.sv
// The first character of a group reaches the outputs once the completed group has been written
//   into the queue and then loaded into the back end's group register, when the back end is idle.
// Throughput: one byte per cycle in while full is low, one character per cycle out while pop is
//   high; the output port sets the pace, since each 3-byte group yields 4 characters.
// The two-entry group queue lets bytes keep arriving while characters drain.
// Reset (rst, synchronous): clears pending count, queue and output; empty goes high.
module base64_stream_encoder import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       last_char
);

  q_stat_t q_stat;
  group_t  grp;
  group_t  q_data;
  logic    grp_valid;
  logic    q_rd;

  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .q_stat    (q_stat),
    .full      (full),
    .grp_valid (grp_valid),
    .grp       (grp)
  );

  b64e_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (grp_valid),
    .wr_data (grp),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .q_stat  (q_stat)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_data),
    .q_stat    (q_stat),
    .q_rd      (q_rd),
    .pop       (pop),
    .empty     (empty),
    .out_char  (out_char),
    .last_char (last_char)
  );

  // A group is never pushed into a full queue
  assert property (@(posedge clk) disable iff (rst) !(grp_valid && q_stat.full))
    else $error("group written into full queue");

  // Back end never reads an empty queue
  assert property (@(posedge clk) disable iff (rst) !(q_rd && q_stat.empty))
    else $error("group read from empty queue");

  // Queue status flags are exclusive
  assert property (@(posedge clk) disable iff (rst) !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

  // Output is empty right after reset
  assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result present after reset");

endmodule

>>> dv/testbench.sv
// Self-checking testbench for base64_stream_encoder: directed table, random messages, scoreboard.
module testbench;
  import b64e_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int LONG_HOLD    = 60;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_LIMIT   = 1000;
  localparam int MAX_REPORTS  = 10;

  logic       clk = 1'b0;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       empty;
  logic       pop;
  logic [7:0] out_char;
  logic       last_char;

  // One expected character on the result side
  typedef struct {
    logic [7:0] code;
    logic       fin;
  } exp_char_t;

  // One row of the directed table; grp holds the four characters, first in the top byte
  typedef struct {
    logic [7:0]  b;
    logic        l;
    logic        typed;
    logic [31:0] grp;
  } dir_row_t;

  exp_char_t char_q[$];
  dir_row_t  dir_tbl[$];

  // Predictor state: first and second waiting byte, and how many are waiting
  logic [7:0] pend_a;
  logic [7:0] pend_b;
  logic [1:0] pend_cnt;

  int errors = 0;
  int idle_cnt;
  bit no_idle;
  bit long_hold;

  base64_stream_encoder u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .empty     (empty),
    .pop       (pop),
    .out_char  (out_char),
    .last_char (last_char)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // 6-bit index to alphabet character
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) return w + 8'd65;
    if (v < 6'd52) return w + 8'd71;
    if (v < 6'd62) return w - 8'd4;
    if (v == 6'd62) return 8'h2B;
    return 8'h2F;
  endfunction

  // Advance the predictor by one byte; returns 1 when a four-character group comes out
  function automatic logic next_quartet(input logic [7:0] b, input logic l,
                                        output logic [31:0] grp);
    logic emits;
    emits = 1'b1;
    grp   = '0;
    if (pend_cnt == CNT_TWO) begin
      grp = {b64_char(pend_a[7:2]), b64_char({pend_a[1:0], pend_b[7:4]}),
             b64_char({pend_b[3:0], b[7:6]}), b64_char(b[5:0])};
    end else if (!l) begin
      emits = 1'b0;
      if (pend_cnt == CNT_NONE) pend_a = b;
      else pend_b = b;
    end else if (pend_cnt == CNT_NONE) begin
      grp = {b64_char(b[7:2]), b64_char({b[1:0], 4'h0}), PAD_CHAR, PAD_CHAR};
    end else begin
      grp = {b64_char(pend_a[7:2]), b64_char({pend_a[1:0], b[7:4]}),
             b64_char({b[3:0], 2'b00}), PAD_CHAR};
    end
    pend_cnt = emits ? CNT_NONE : pend_cnt + 2'd1;
    return emits;
  endfunction

  task automatic add_row(input logic [7:0] b, input logic l, input logic typed,
                         input logic [31:0] grp);
    dir_row_t r;
    r.b     = b;
    r.l     = l;
    r.typed = typed;
    r.grp   = grp;
    dir_tbl.push_back(r);
  endtask

  // Offer one byte, wait for the input transaction, then queue what it produces
  task automatic offer_byte(input logic [7:0] b, input logic l, input logic typed,
                            input logic [31:0] typed_grp);
    int          gap;
    logic [31:0] grp;
    logic        emits;
    exp_char_t   e;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    do @(posedge clk); while (full);
    emits = next_quartet(b, l, grp);
    if (typed) grp = typed_grp;
    if (emits) begin
      for (int i = 0; i < 4; i++) begin
        e.code = grp[31 - 8 * i -: 8];
        e.fin  = (i == 3) && l;
        char_q.push_back(e);
      end
    end
  endtask

  // Stop offering and wait until every queued character has come out
  task automatic drain_pause();
    push <= 1'b0;
    @(posedge clk);
    wait (char_q.size() == 0);
  endtask

  // Compare one output transaction against the oldest expectation
  task automatic check_char(input logic [7:0] code, input logic fin);
    exp_char_t e;
    if (char_q.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("mismatch: unexpected char %02h last %0b", code, fin);
    end else begin
      e = char_q.pop_front();
      if (code !== e.code || fin !== e.fin) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch: char exp %02h got %02h, last exp %0b got %0b",
                   e.code, code, e.fin, fin);
      end
    end
  endtask

  // Receiver: random pops, one long hold-off on request
  initial begin
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    pop       = 1'b0;
    wait (rst == 1'b0);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (long_hold && !hold_done) begin
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      check_char(out_char, last_char);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, random messages, drain
  initial begin
    int          sent;
    int          msg_len;
    int          next_seg;
    logic [7:0]  b;
    rst       = 1'b1;
    push      = 1'b0;
    data_byte = 8'h00;
    last_byte = 1'b0;
    no_idle   = 1'b0;
    long_hold = 1'b0;
    pend_a    = 8'h00;
    pend_b    = 8'h00;
    pend_cnt  = CNT_NONE;

    // one-byte messages at the extremes
    add_row(8'h00, 1'b1, 1'b1, "AA==");
    add_row(8'hFF, 1'b1, 1'b1, "/w==");
    // two-byte messages at the extremes
    add_row(8'h00, 1'b0, 1'b0, 32'h0);
    add_row(8'h00, 1'b1, 1'b1, "AAA=");
    add_row(8'hFF, 1'b0, 1'b0, 32'h0);
    add_row(8'hFF, 1'b1, 1'b1, "//8=");
    // full group not last, then a full group marked last
    add_row(8'h00, 1'b0, 1'b0, 32'h0);
    add_row(8'h00, 1'b0, 1'b0, 32'h0);
    add_row(8'h00, 1'b0, 1'b1, "AAAA");
    add_row(8'hFF, 1'b0, 1'b0, 32'h0);
    add_row(8'hFF, 1'b0, 1'b0, 32'h0);
    add_row(8'hFF, 1'b1, 1'b1, "////");
    // mixed bit patterns, all three tail lengths
    add_row(8'h4D, 1'b0, 1'b0, 32'h0);
    add_row(8'h61, 1'b0, 1'b0, 32'h0);
    add_row(8'h6E, 1'b1, 1'b0, 32'h0);
    add_row(8'h4D, 1'b0, 1'b0, 32'h0);
    add_row(8'h61, 1'b1, 1'b0, 32'h0);
    add_row(8'h4D, 1'b1, 1'b0, 32'h0);
    // group followed by a lone last byte, then a three-byte message
    add_row(8'hA5, 1'b0, 1'b0, 32'h0);
    add_row(8'h5A, 1'b0, 1'b0, 32'h0);
    add_row(8'hC3, 1'b0, 1'b0, 32'h0);
    add_row(8'h3C, 1'b1, 1'b0, 32'h0);
    add_row(8'h80, 1'b0, 1'b0, 32'h0);
    add_row(8'h01, 1'b0, 1'b0, 32'h0);
    add_row(8'h7F, 1'b1, 1'b0, 32'h0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i])
      offer_byte(dir_tbl[i].b, dir_tbl[i].l, dir_tbl[i].typed, dir_tbl[i].grp);
    drain_pause();

    // back-to-back bytes while the receiver holds off, so the block fills up
    no_idle   = 1'b1;
    long_hold = 1'b1;
    sent      = 0;
    next_seg  = 50;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= next_seg) begin
        no_idle  = ($urandom_range(0, 2) == 0);
        next_seg = sent + $urandom_range(30, 70);
      end
      if ($urandom_range(0, 24) == 0) drain_pause();
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      for (int k = 0; k < msg_len; k++) begin
        if ($urandom_range(0, 7) == 0) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else b = 8'($urandom_range(0, 255));
        offer_byte(b, k == msg_len - 1, 1'b0, 32'h0);
        sent++;
      end
    end

    // wait out the tail, watching for stray characters
    drain_pause();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
